FILE: sv/wmpz_pkg.sv
// Shared types, constants and helpers for the W-mass neutrino pz solver.
package wmpz_pkg;

    // Internal word: wide enough for pz^2 times the discriminant.
    localparam int W = 150;
    // Bits of numerator handled by the serial divider.
    localparam int DIV_BITS = 96;
    // Bits of radicand handled by the serial square root (two per step).
    localparam int SQ_BITS = 148;
    localparam int CNT_W = $clog2(DIV_BITS);
    localparam int STEP_ONE = 1024;
    localparam int STEP_LOG2 = 10;

    localparam logic [18-1:0] W_MASS_RESET = 18'd80385;
    localparam logic [11-1:0] SHIFT_STEP_RESET = 11'd102;

    localparam logic [1:0] ST_SOLVED = 2'd0;
    localparam logic [1:0] ST_NO_ROOT = 2'd1;
    localparam logic [1:0] ST_DEGENERATE = 2'd2;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_SQRT = 3'd4;
    localparam logic [2:0] OP_SHR = 3'd5;

    localparam logic REG_W_MASS = 1'b0;
    localparam logic REG_SHIFT_STEP = 1'b1;

    typedef logic signed [W-1:0] wide_t;

    typedef struct packed {
        logic signed [23:0] lep_px;
        logic signed [23:0] lep_py;
        logic signed [23:0] lep_pz;
        logic [22:0]        lep_energy;
        logic signed [23:0] met_x;
        logic signed [23:0] met_y;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] nu_px;
        logic signed [23:0] nu_py;
        logic signed [31:0] first_pz;
        logic signed [31:0] first_energy;
        logic signed [31:0] second_pz;
        logic signed [31:0] second_energy;
        logic [6:0]         retries;
        logic [1:0]         status;
    } out_item_t;

    typedef struct packed {
        logic       start;
        logic [2:0] op;
        wide_t      a;
        wide_t      b;
    } alu_req_t;

    typedef struct packed {
        logic  done;
        wide_t y;
    } alu_rsp_t;

    function automatic wide_t ext24(input logic signed [23:0] v);
        return {{(W-24){v[23]}}, v};
    endfunction

    function automatic wide_t extu(input logic [22:0] v);
        return {{(W-23){1'b0}}, v};
    endfunction

    // Clamp a wide signed value into 32-bit signed range.
    function automatic logic signed [31:0] sat32(input wide_t v);
        logic all0;
        logic all1;
        all0 = (v[W-1:31] == '0);
        all1 = (v[W-1:31] == '1);
        if (all0 || all1) begin
            return v[31:0];
        end
        return v[W-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
    endfunction

endpackage

FILE: sv/wmpz_alu.sv
// Shared serial arithmetic unit: add, subtract, multiply, divide, square root and arithmetic shift right.
module wmpz_alu import wmpz_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    localparam logic [3:0] P_IDLE = 4'd0;
    localparam logic [3:0] P_ADD  = 4'd1;
    localparam logic [3:0] P_NEGA = 4'd2;
    localparam logic [3:0] P_NEGB = 4'd3;
    localparam logic [3:0] P_MUL  = 4'd4;
    localparam logic [3:0] P_DIV  = 4'd5;
    localparam logic [3:0] P_SQRT = 4'd6;
    localparam logic [3:0] P_FIN  = 4'd7;
    localparam logic [3:0] P_NEGY = 4'd8;
    localparam logic [3:0] P_SHR  = 4'd9;

    logic [3:0]       phase_reg;
    logic [2:0]       op_reg;
    wide_t            opa_reg;
    wide_t            opb_reg;
    wide_t            acc_reg;
    wide_t            y_reg;
    logic             neg_y_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;

    wide_t add_x;
    wide_t add_y;
    logic  add_inv;
    wide_t sum;
    wide_t rem_div;
    wide_t rem_sq;
    wide_t trial;
    wide_t shr_mask;
    wide_t result;
    logic  ok;
    logic  req_signed;

    function automatic logic [3:0] run_phase(input logic [2:0] op);
        if (op == OP_MUL) begin
            return P_MUL;
        end
        if (op == OP_DIV) begin
            return P_DIV;
        end
        return P_SQRT;
    endfunction

    assign req_signed = (req.op == OP_MUL) || (req.op == OP_DIV);
    assign rem_div = {acc_reg[W-2:0], opa_reg[DIV_BITS-1]};
    assign rem_sq  = {acc_reg[W-3:0], opa_reg[SQ_BITS-1 -: 2]};
    assign trial   = {opb_reg[W-3:0], 2'b01};
    // Bias that makes the arithmetic shift truncate toward zero on negative values.
    assign shr_mask = ~({W{1'b1}} << opb_reg[3:0]);

    always_comb begin
        add_x = '0;
        add_y = '0;
        add_inv = 1'b0;
        unique case (phase_reg)
            P_ADD: begin
                add_x = opa_reg;
                add_y = opb_reg;
                add_inv = (op_reg == OP_SUB);
            end
            P_NEGA: begin
                add_y = opa_reg;
                add_inv = 1'b1;
            end
            P_NEGB: begin
                add_y = opb_reg;
                add_inv = 1'b1;
            end
            P_MUL: begin
                add_x = acc_reg;
                add_y = opa_reg;
            end
            P_DIV: begin
                add_x = rem_div;
                add_y = opb_reg;
                add_inv = 1'b1;
            end
            P_SQRT: begin
                add_x = rem_sq;
                add_y = trial;
                add_inv = 1'b1;
            end
            P_NEGY: begin
                add_y = y_reg;
                add_inv = 1'b1;
            end
            P_SHR: begin
                add_x = opa_reg;
                add_y = opa_reg[W-1] ? shr_mask : '0;
            end
            default: begin
            end
        endcase
        sum = add_x + (add_inv ? ~add_y : add_y) + {{(W-1){1'b0}}, add_inv};
        ok = !sum[W-1];
    end

    always_comb begin
        unique case (op_reg)
            OP_MUL:  result = acc_reg;
            OP_DIV:  result = {{(W-DIV_BITS){1'b0}}, opa_reg[DIV_BITS-1:0]};
            default: result = opb_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= P_IDLE;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (phase_reg)
                P_IDLE: begin
                    if (req.start) begin
                        opa_reg <= req.a;
                        opb_reg <= req.b;
                        acc_reg <= '0;
                        cnt_reg <= '0;
                        op_reg <= req.op;
                        neg_y_reg <= req_signed && (req.a[W-1] ^ req.b[W-1]);
                        if (req.op == OP_ADD || req.op == OP_SUB) begin
                            phase_reg <= P_ADD;
                        end else if (req.op == OP_SHR) begin
                            phase_reg <= P_SHR;
                        end else if (req_signed && req.a[W-1]) begin
                            phase_reg <= P_NEGA;
                        end else if (req_signed && req.b[W-1]) begin
                            phase_reg <= P_NEGB;
                        end else begin
                            phase_reg <= run_phase(req.op);
                        end
                    end
                end
                P_ADD: begin
                    y_reg <= sum;
                    done_reg <= 1'b1;
                    phase_reg <= P_IDLE;
                end
                P_SHR: begin
                    y_reg <= sum >>> opb_reg[3:0];
                    done_reg <= 1'b1;
                    phase_reg <= P_IDLE;
                end
                P_NEGA: begin
                    opa_reg <= sum;
                    phase_reg <= opb_reg[W-1] ? P_NEGB : run_phase(op_reg);
                end
                P_NEGB: begin
                    opb_reg <= sum;
                    phase_reg <= run_phase(op_reg);
                end
                P_MUL: begin
                    // Stops as soon as the multiplier runs out of set bits.
                    if (opb_reg == '0) begin
                        phase_reg <= P_FIN;
                    end else begin
                        if (opb_reg[0]) begin
                            acc_reg <= sum;
                        end
                        opa_reg <= opa_reg << 1;
                        opb_reg <= opb_reg >> 1;
                    end
                end
                P_DIV: begin
                    acc_reg <= ok ? sum : rem_div;
                    opa_reg <= {opa_reg[W-2:0], ok};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DIV_BITS - 1)) begin
                        phase_reg <= P_FIN;
                    end
                end
                P_SQRT: begin
                    acc_reg <= ok ? sum : rem_sq;
                    opb_reg <= {opb_reg[W-2:0], ok};
                    opa_reg <= opa_reg << 2;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(SQ_BITS / 2 - 1)) begin
                        phase_reg <= P_FIN;
                    end
                end
                P_FIN: begin
                    y_reg <= result;
                    if (neg_y_reg) begin
                        phase_reg <= P_NEGY;
                    end else begin
                        done_reg <= 1'b1;
                        phase_reg <= P_IDLE;
                    end
                end
                P_NEGY: begin
                    y_reg <= sum;
                    done_reg <= 1'b1;
                    phase_reg <= P_IDLE;
                end
                default: begin
                    phase_reg <= P_IDLE;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.y = y_reg;

endmodule

FILE: sv/wmpz_seq.sv
// Sequencer that steps the solver program through the shared arithmetic unit.
module wmpz_seq import wmpz_pkg::*; #(
    parameter int MAX_RETRIES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [17:0] w_mass,
    input  logic [10:0] shift_step,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    localparam logic [5:0] ST_IDLE = 6'd0;
    localparam logic [5:0] ST_E2   = 6'd1;
    localparam logic [5:0] ST_PZ2  = 6'd2;
    localparam logic [5:0] ST_S    = 6'd3;
    localparam logic [5:0] ST_PX2  = 6'd4;
    localparam logic [5:0] ST_MSQ1 = 6'd5;
    localparam logic [5:0] ST_PY2  = 6'd6;
    localparam logic [5:0] ST_MSQ2 = 6'd7;
    localparam logic [5:0] ST_MW2  = 6'd8;
    localparam logic [5:0] ST_HT   = 6'd9;
    localparam logic [5:0] ST_HALF = 6'd10;
    localparam logic [5:0] ST_LX   = 6'd11;
    localparam logic [5:0] ST_L1   = 6'd12;
    localparam logic [5:0] ST_LY   = 6'd13;
    localparam logic [5:0] ST_L2   = 6'd14;
    localparam logic [5:0] ST_MX2  = 6'd15;
    localparam logic [5:0] ST_MY2  = 6'd16;
    localparam logic [5:0] ST_M    = 6'd17;
    localparam logic [5:0] ST_LSQ  = 6'd18;
    localparam logic [5:0] ST_SM   = 6'd19;
    localparam logic [5:0] ST_D    = 6'd20;
    localparam logic [5:0] ST_DX   = 6'd21;
    localparam logic [5:0] ST_DXS  = 6'd22;
    localparam logic [5:0] ST_DXQ  = 6'd23;
    localparam logic [5:0] ST_NX   = 6'd24;
    localparam logic [5:0] ST_DY   = 6'd25;
    localparam logic [5:0] ST_DYS  = 6'd26;
    localparam logic [5:0] ST_DYQ  = 6'd27;
    localparam logic [5:0] ST_NY   = 6'd28;
    localparam logic [5:0] ST_PD   = 6'd29;
    localparam logic [5:0] ST_SQ   = 6'd30;
    localparam logic [5:0] ST_EL   = 6'd31;
    localparam logic [5:0] ST_PL   = 6'd32;
    localparam logic [5:0] ST_ER   = 6'd33;
    localparam logic [5:0] ST_DEN  = 6'd34;
    localparam logic [5:0] ST_N1   = 6'd35;
    localparam logic [5:0] ST_Q1   = 6'd36;
    localparam logic [5:0] ST_N2   = 6'd37;
    localparam logic [5:0] ST_Q2   = 6'd38;
    localparam logic [5:0] ST_N3   = 6'd39;
    localparam logic [5:0] ST_Q3   = 6'd40;
    localparam logic [5:0] ST_N4   = 6'd41;
    localparam logic [5:0] ST_Q4   = 6'd42;
    localparam logic [5:0] ST_OUT  = 6'd43;

    logic [5:0]         state_reg;
    logic               issued_reg;
    in_item_t           in_reg;
    logic signed [23:0] mx_reg;
    logic signed [23:0] my_reg;
    logic [10:0]        step_reg;
    logic [6:0]         retries_reg;
    logic [1:0]         status_reg;
    logic signed [31:0] f1p_reg;
    logic signed [31:0] f1e_reg;
    logic signed [31:0] f2p_reg;
    logic signed [31:0] f2e_reg;
    wide_t pz2_reg;
    wide_t s_reg;
    wide_t half_reg;
    wide_t l_reg;
    wide_t m_reg;
    wide_t t_reg;
    wide_t u_reg;
    wide_t r_reg;
    wide_t el_reg;
    wide_t pl_reg;
    wide_t er_reg;
    wide_t den_reg;
    logic      m_valid_reg;
    out_item_t m_data_reg;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;
    logic     op_state;
    logic     out_free;

    wmpz_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .rsp     (alu_rsp)
    );

    assign op_state = (state_reg != ST_IDLE) && (state_reg != ST_OUT);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready = (state_reg == ST_IDLE);

    // Program table: operation and operands for each step.
    always_comb begin
        alu_req.start = op_state && !issued_reg;
        alu_req.op = OP_ADD;
        alu_req.a = '0;
        alu_req.b = '0;
        unique case (state_reg)
            ST_E2: begin
                alu_req.op = OP_MUL;
                alu_req.a = extu(in_reg.lep_energy);
                alu_req.b = extu(in_reg.lep_energy);
            end
            ST_PZ2: begin
                alu_req.op = OP_MUL;
                alu_req.a = ext24(in_reg.lep_pz);
                alu_req.b = ext24(in_reg.lep_pz);
            end
            ST_S: begin
                alu_req.op = OP_SUB;
                alu_req.a = t_reg;
                alu_req.b = pz2_reg;
            end
            ST_PX2: begin
                alu_req.op = OP_MUL;
                alu_req.a = ext24(in_reg.lep_px);
                alu_req.b = ext24(in_reg.lep_px);
            end
            ST_MSQ1: begin
                alu_req.op = OP_SUB;
                alu_req.a = s_reg;
                alu_req.b = t_reg;
            end
            ST_PY2: begin
                alu_req.op = OP_MUL;
                alu_req.a = ext24(in_reg.lep_py);
                alu_req.b = ext24(in_reg.lep_py);
            end
            ST_MSQ2: begin
                alu_req.op = OP_SUB;
                alu_req.a = u_reg;
                alu_req.b = t_reg;
            end
            ST_MW2: begin
                alu_req.op = OP_MUL;
                alu_req.a = {{(W-18){1'b0}}, w_mass};
                alu_req.b = {{(W-18){1'b0}}, w_mass};
            end
            ST_HT: begin
                alu_req.op = OP_SUB;
                alu_req.a = t_reg;
                alu_req.b = u_reg;
            end
            ST_HALF: begin
                alu_req.op = OP_SHR;
                alu_req.a = t_reg;
                alu_req.b = W'(1);
            end
            ST_LX: begin
                alu_req.op = OP_MUL;
                alu_req.a = ext24(in_reg.lep_px);
                alu_req.b = ext24(mx_reg);
            end
            ST_L1: begin
                alu_req.a = half_reg;
                alu_req.b = t_reg;
            end
            ST_LY: begin
                alu_req.op = OP_MUL;
                alu_req.a = ext24(in_reg.lep_py);
                alu_req.b = ext24(my_reg);
            end
            ST_L2: begin
                alu_req.a = l_reg;
                alu_req.b = t_reg;
            end
            ST_MX2: begin
                alu_req.op = OP_MUL;
                alu_req.a = ext24(mx_reg);
                alu_req.b = ext24(mx_reg);
            end
            ST_MY2: begin
                alu_req.op = OP_MUL;
                alu_req.a = ext24(my_reg);
                alu_req.b = ext24(my_reg);
            end
            ST_M: begin
                alu_req.a = t_reg;
                alu_req.b = u_reg;
            end
            ST_LSQ: begin
                alu_req.op = OP_MUL;
                alu_req.a = l_reg;
                alu_req.b = l_reg;
            end
            ST_SM: begin
                alu_req.op = OP_MUL;
                alu_req.a = m_reg;
                alu_req.b = s_reg;
            end
            ST_D: begin
                alu_req.op = OP_SUB;
                alu_req.a = t_reg;
                alu_req.b = u_reg;
            end
            ST_DX: begin
                alu_req.op = OP_SUB;
                alu_req.a = ext24(in_reg.lep_px);
                alu_req.b = ext24(mx_reg);
            end
            ST_DY: begin
                alu_req.op = OP_SUB;
                alu_req.a = ext24(in_reg.lep_py);
                alu_req.b = ext24(my_reg);
            end
            ST_DXS, ST_DYS: begin
                alu_req.op = OP_MUL;
                alu_req.a = u_reg;
                alu_req.b = {{(W-11){1'b0}}, step_reg};
            end
            ST_DXQ, ST_DYQ: begin
                alu_req.op = OP_SHR;
                alu_req.a = u_reg;
                alu_req.b = W'(STEP_LOG2);
            end
            ST_NX: begin
                alu_req.a = ext24(mx_reg);
                alu_req.b = u_reg;
            end
            ST_NY: begin
                alu_req.a = ext24(my_reg);
                alu_req.b = u_reg;
            end
            ST_PD: begin
                alu_req.op = OP_MUL;
                alu_req.a = t_reg;
                alu_req.b = pz2_reg;
            end
            ST_SQ: begin
                alu_req.op = OP_SQRT;
                alu_req.a = t_reg;
            end
            ST_EL: begin
                alu_req.op = OP_MUL;
                alu_req.a = l_reg;
                alu_req.b = extu(in_reg.lep_energy);
            end
            ST_PL: begin
                alu_req.op = OP_MUL;
                alu_req.a = l_reg;
                alu_req.b = pz2_reg;
            end
            ST_ER: begin
                alu_req.op = OP_MUL;
                alu_req.a = r_reg;
                alu_req.b = extu(in_reg.lep_energy);
            end
            ST_DEN: begin
                alu_req.op = OP_MUL;
                alu_req.a = s_reg;
                alu_req.b = ext24(in_reg.lep_pz);
            end
            ST_N1: begin
                alu_req.op = OP_SUB;
                alu_req.a = el_reg;
                alu_req.b = r_reg;
            end
            ST_N2: begin
                alu_req.op = OP_SUB;
                alu_req.a = pl_reg;
                alu_req.b = er_reg;
            end
            ST_N3: begin
                alu_req.a = el_reg;
                alu_req.b = r_reg;
            end
            ST_N4: begin
                alu_req.a = pl_reg;
                alu_req.b = er_reg;
            end
            ST_Q1, ST_Q3: begin
                alu_req.op = OP_DIV;
                alu_req.a = t_reg;
                alu_req.b = s_reg;
            end
            ST_Q2, ST_Q4: begin
                alu_req.op = OP_DIV;
                alu_req.a = t_reg;
                alu_req.b = den_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            issued_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            if (alu_req.start) begin
                issued_reg <= 1'b1;
            end
            if (state_reg == ST_IDLE) begin
                if (s_valid) begin
                    in_reg <= s_data;
                    mx_reg <= s_data.met_x;
                    my_reg <= s_data.met_y;
                    step_reg <= (shift_step > 11'(STEP_ONE)) ? 11'(STEP_ONE) : shift_step;
                    retries_reg <= '0;
                    f1p_reg <= '0;
                    f1e_reg <= '0;
                    f2p_reg <= '0;
                    f2e_reg <= '0;
                    state_reg <= ST_E2;
                end
            end else if (state_reg == ST_OUT) begin
                if (out_free) begin
                    m_data_reg.nu_px <= mx_reg;
                    m_data_reg.nu_py <= my_reg;
                    m_data_reg.first_pz <= f1p_reg;
                    m_data_reg.first_energy <= f1e_reg;
                    m_data_reg.second_pz <= f2p_reg;
                    m_data_reg.second_energy <= f2e_reg;
                    m_data_reg.retries <= retries_reg;
                    m_data_reg.status <= status_reg;
                    m_valid_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
            end else if (alu_rsp.done) begin
                issued_reg <= 1'b0;
                state_reg <= state_reg + 1'b1;
                unique case (state_reg)
                    ST_E2, ST_PX2, ST_PY2, ST_MW2, ST_HT, ST_LX, ST_LY, ST_MX2,
                    ST_LSQ, ST_PD, ST_N1, ST_N2, ST_N3, ST_N4: begin
                        t_reg <= alu_rsp.y;
                    end
                    ST_PZ2: pz2_reg <= alu_rsp.y;
                    ST_S: begin
                        s_reg <= alu_rsp.y;
                        // Zero pz, or lepton energy equal to |pz|, has no usable quadratic.
                        if (alu_rsp.y == '0 || pz2_reg == '0) begin
                            status_reg <= ST_DEGENERATE;
                            state_reg <= ST_OUT;
                        end
                    end
                    ST_MSQ1, ST_MSQ2, ST_MY2, ST_SM, ST_DX, ST_DXS, ST_DXQ,
                    ST_DY, ST_DYS, ST_DYQ: begin
                        u_reg <= alu_rsp.y;
                    end
                    ST_HALF: half_reg <= alu_rsp.y;
                    ST_L1, ST_L2: l_reg <= alu_rsp.y;
                    ST_M: m_reg <= alu_rsp.y;
                    ST_D: begin
                        t_reg <= alu_rsp.y;
                        if (!alu_rsp.y[W-1]) begin
                            state_reg <= ST_PD;
                        end else if (retries_reg >= 7'(MAX_RETRIES)) begin
                            status_reg <= ST_NO_ROOT;
                            state_reg <= ST_OUT;
                        end
                    end
                    ST_NX: mx_reg <= alu_rsp.y[23:0];
                    ST_NY: begin
                        my_reg <= alu_rsp.y[23:0];
                        retries_reg <= retries_reg + 1'b1;
                        state_reg <= ST_LX;
                    end
                    ST_SQ: r_reg <= alu_rsp.y;
                    ST_EL: el_reg <= alu_rsp.y;
                    ST_PL: pl_reg <= alu_rsp.y;
                    ST_ER: er_reg <= alu_rsp.y;
                    ST_DEN: den_reg <= alu_rsp.y;
                    ST_Q1: f1e_reg <= sat32(alu_rsp.y);
                    ST_Q2: f1p_reg <= sat32(alu_rsp.y);
                    ST_Q3: f2e_reg <= sat32(alu_rsp.y);
                    ST_Q4: begin
                        f2p_reg <= sat32(alu_rsp.y);
                        status_reg <= ST_SOLVED;
                    end
                    default: begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

endmodule

FILE: sv/w_mass_neutrino_pz_solver_top.sv
// Top level: register port, solver sequencer and result checks.
// The shared serial unit works one multiplier bit, quotient bit or
// root bit per cycle; each of the four divides takes 96 steps and the root 74.
// Throughput: one item at a time; the next beat is taken while a result waits.
// Reset: synchronous active-low aresetn idles the sequencer and restores the registers.
module w_mass_neutrino_pz_solver_top import wmpz_pkg::*; #(
    parameter int MAX_RETRIES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    logic [17:0] w_mass_reg;
    logic [10:0] shift_step_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_mass_reg <= W_MASS_RESET;
            shift_step_reg <= SHIFT_STEP_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_W_MASS:     w_mass_reg <= pwdata[17:0];
                REG_SHIFT_STEP: shift_step_reg <= pwdata[10:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_W_MASS:     prdata = {14'd0, w_mass_reg};
            REG_SHIFT_STEP: prdata = {21'd0, shift_step_reg};
            default:        prdata = '0;
        endcase
    end

    wmpz_seq #(
        .MAX_RETRIES (MAX_RETRIES)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .w_mass     (w_mass_reg),
        .shift_step (shift_step_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // Once a beat is taken the solver is busy on it.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while solver busy");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status != 2'd3))
        else $error("undefined status code");

    a_no_root_retries: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_NO_ROOT) |-> (m_data.retries == 7'(MAX_RETRIES)))
        else $error("no-root result without exhausted retries");

    a_degenerate_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_DEGENERATE) |->
        (m_data.retries == '0 && m_data.first_pz == '0 && m_data.second_energy == '0))
        else $error("degenerate result carries data");

endmodule

FILE: verif/w_mass_neutrino_pz_solver_checker.sv
// Checker for the W-mass neutrino pz solver: tracks registers, predicts results, compares beats.
`timescale 1ns / 1ps

module w_mass_neutrino_pz_solver_checker import wmpz_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_item_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_item_t   m_data,
    output int          fail_count,
    output int          outstanding,
    output int          results_seen,
    output int          solved_seen,
    output int          no_root_seen,
    output int          degenerate_seen
);

    localparam int RETRY_CAP = 64;

    typedef logic signed [191:0] big_t;

    logic [17:0] mass_reg;
    logic [10:0] step_reg;
    out_item_t   expected_q[$];

    initial begin
        fail_count = 0;
        results_seen = 0;
        solved_seen = 0;
        no_root_seen = 0;
        degenerate_seen = 0;
    end

    assign outstanding = expected_q.size();

    function automatic logic [191:0] floor_root(input logic [191:0] n);
        logic [191:0] res;
        logic [191:0] bitv;
        res = '0;
        bitv = 192'd1 << 190;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] clamp32(input big_t v);
        if (v > big_t'(64'sd2147483647)) return 32'sh7FFFFFFF;
        if (v < big_t'(-64'sd2147483648)) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic out_item_t solve_pz(input in_item_t it, input logic [17:0] wm,
                                           input logic [10:0] st);
        longint px, py, pz, e, mx, my, stp, s, pz2, msq, half, l, mw;
        big_t wl, d, r, el, pl, er, den, ws, we;
        out_item_t o;
        int n;
        logic [1:0] stt;
        px = it.lep_px;
        py = it.lep_py;
        pz = it.lep_pz;
        e = longint'(it.lep_energy);
        mx = it.met_x;
        my = it.met_y;
        mw = longint'(wm);
        stp = (st > 11'd1024) ? 1024 : longint'(st);
        s = e * e - pz * pz;
        pz2 = pz * pz;
        msq = e * e - px * px - py * py - pz * pz;
        half = (mw * mw - msq) / 2;
        o = '0;
        n = 0;
        if (pz == 0 || s == 0) begin
            stt = ST_DEGENERATE;
        end else begin
            while (1) begin
                l = half + mx * px + my * py;
                wl = big_t'(l);
                d = wl * wl - big_t'(s) * big_t'(mx * mx + my * my);
                if (!d[191]) begin
                    r = big_t'(floor_root(big_t'(pz2) * d));
                    we = big_t'(e);
                    ws = big_t'(s);
                    el = we * wl;
                    pl = big_t'(pz2) * wl;
                    er = we * r;
                    den = big_t'(pz) * ws;
                    o.first_energy = clamp32((el - r) / ws);
                    o.first_pz = clamp32((pl - er) / den);
                    o.second_energy = clamp32((el + r) / ws);
                    o.second_pz = clamp32((pl + er) / den);
                    stt = ST_SOLVED;
                    break;
                end
                if (n >= RETRY_CAP) begin
                    stt = ST_NO_ROOT;
                    break;
                end
                mx = mx + ((px - mx) * stp) / 1024;
                my = my + ((py - my) * stp) / 1024;
                n++;
            end
        end
        o.nu_px = mx[23:0];
        o.nu_py = my[23:0];
        o.retries = n[6:0];
        o.status = stt;
        return o;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            mass_reg <= W_MASS_RESET;
            step_reg <= SHIFT_STEP_RESET;
            expected_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == 3'd0) mass_reg <= pwdata[17:0];
                else if (paddr == 3'd4) step_reg <= pwdata[10:0];
            end
            if (s_valid && s_ready) expected_q.push_back(solve_pz(s_data, mass_reg, step_reg));
            if (m_valid && m_ready) begin
                results_seen++;
                case (m_data.status)
                    ST_SOLVED:     solved_seen++;
                    ST_NO_ROOT:    no_root_seen++;
                    ST_DEGENERATE: degenerate_seen++;
                    default: ;
                endcase
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result beat: %p", m_data);
                end else begin
                    want = expected_q.pop_front();
                    if (m_data.nu_px !== want.nu_px || m_data.nu_py !== want.nu_py ||
                        m_data.first_pz !== want.first_pz ||
                        m_data.first_energy !== want.first_energy ||
                        m_data.second_pz !== want.second_pz ||
                        m_data.second_energy !== want.second_energy ||
                        m_data.retries !== want.retries || m_data.status !== want.status) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("result mismatch at %0t", $realtime);
                            $display("  expected %p", want);
                            $display("  actual   %p", m_data);
                        end
                    end
                end
            end
        end
    end

endmodule

FILE: verif/w_mass_neutrino_pz_solver_top_test.sv
// Testbench top: drives the W-mass neutrino pz solver and reports the verdict.
`timescale 1ns / 1ps

module w_mass_neutrino_pz_solver_top_test;
    import wmpz_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;

    int fail_count, outstanding, results_seen, solved_seen, no_root_seen, degenerate_seen;
    int items_sent = 0;
    int phases_run = 0;
    bit calm = 1'b0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int stall_left = 0;

    always #5 aclk = ~aclk;

    w_mass_neutrino_pz_solver_top i_dut (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data
    );

    w_mass_neutrino_pz_solver_checker i_checker (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .fail_count, .outstanding, .results_seen, .solved_seen, .no_root_seen,
        .degenerate_seen
    );

    // Result side: random back-pressure, plus long hold-offs on request.
    always @(posedge aclk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            stall_left = 3000;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 13);
        end
    end

    initial begin
        #2s;
        $display("[w_mass_neutrino_pz_solver_top] ERROR");
        $finish;
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    // Upper data bits are random; the block keeps only the register width.
    task automatic set_config(input logic [17:0] wm, input logic [10:0] st);
        reg_write(3'd0, {14'($urandom_range(16383)), wm});
        reg_write(3'd4, {21'($urandom_range(2097151)), st});
    endtask

    task automatic send_beat(input in_item_t it);
        int gap;
        if (!calm && $urandom_range(99) < 13) begin
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    function automatic logic signed [23:0] rand_comp(input int mag_bits);
        int v;
        v = $urandom_range((1 << mag_bits) - 1);
        return 24'($urandom_range(1) ? -v : v);
    endfunction

    // A physical-looking lepton: energy from its momentum plus a small mass.
    function automatic in_item_t make_event;
        in_item_t it;
        real p2;
        int mb;
        mb = $urandom_range(6, 22);
        it.lep_px = rand_comp(mb);
        it.lep_py = rand_comp(mb);
        it.lep_pz = rand_comp(mb);
        p2 = real'(it.lep_px) ** 2 + real'(it.lep_py) ** 2 + real'(it.lep_pz) ** 2
             + real'($urandom_range(1000)) ** 2;
        it.lep_energy = 23'($rtoi($sqrt(p2)));
        mb = $urandom_range(4, 22);
        it.met_x = rand_comp(mb);
        it.met_y = rand_comp(mb);
        return it;
    endfunction

    function automatic in_item_t make_noise;
        in_item_t it;
        it.lep_px = 24'($urandom);
        it.lep_py = 24'($urandom);
        it.lep_pz = 24'($urandom);
        it.lep_energy = 23'($urandom);
        it.met_x = 24'($urandom);
        it.met_y = 24'($urandom);
        return it;
    endfunction

    function automatic in_item_t pack_beat(input int px, input int py, input int pz,
                                           input int e, input int mx, input int my);
        in_item_t it;
        it.lep_px = 24'(px);
        it.lep_py = 24'(py);
        it.lep_pz = 24'(pz);
        it.lep_energy = 23'(e);
        it.met_x = 24'(mx);
        it.met_y = 24'(my);
        return it;
    endfunction

    initial begin
        logic [17:0] masses[8];
        logic [10:0] steps[8];
        in_item_t it;
        masses = '{18'd80385, 18'd262143, 18'd0, 18'd80385,
                   18'd91188, 18'd1, 18'd262143, 18'd40000};
        steps = '{11'd102, 11'd1024, 11'd1, 11'd2047, 11'd512, 11'd102, 11'd1, 11'd300};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed beats with the reset register values.
        send_beat(pack_beat(8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
        send_beat(pack_beat(-8388608, -8388608, -8388608, 0, -8388608, -8388608));
        send_beat(pack_beat(30000, -20000, 0, 50000, 10000, 5000));
        send_beat(pack_beat(30000, -20000, 40000, 40000, 10000, 5000));
        send_beat(pack_beat(30000, -20000, -40000, 40000, 1, -1));
        send_beat(pack_beat(100, 200, 300, 0, 400, 500));
        send_beat(pack_beat(30000, 40000, 50000, 80000, 0, 0));
        send_beat(pack_beat(30000, 40000, 50000, 80000, 30000, 40000));
        send_beat(pack_beat(25000, 10000, 60000, 70000, -40000, 35000));
        send_beat(pack_beat(-1, -1, -1, 8388607, 8388607, -8388608));
        send_beat(pack_beat(1, 0, 1, 2, 0, 0));
        send_beat(pack_beat(4000000, -4000000, 4000000, 6928203, -8388608, 8388607));
        drain();

        // Zero discriminant: the lepton mass equals the W mass and no missing momentum.
        set_config(18'd3, 11'd102);
        send_beat(pack_beat(0, 0, 4, 5, 0, 0));
        send_beat(pack_beat(0, 0, -4, 5, 0, 0));
        drain();

        // Step of zero never moves the missing momentum.
        set_config(18'd80385, 11'd0);
        send_beat(pack_beat(40000, 0, 20000, 44722, -40000, 0));
        for (int i = 0; i < 4; i++) send_beat(make_event());
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            set_config(masses[ph], steps[ph]);
            calm = (ph == 2);
            for (int i = 0; i < 200; i++) begin
                it = ($urandom_range(99) < 4) ? make_noise() : make_event();
                send_beat(it);
                if (ph == 1 && i == 60) hold_reqs++;
                if (ph == 4 && i == 100) drain();
            end
            drain();
            phases_run++;
        end
        calm = 1'b0;

        repeat (2000) @(posedge aclk);
        $display("Sent %0d beats over %0d register settings; %0d results checked.",
                 items_sent, phases_run + 3, results_seen);
        $display("Results: %0d solved, %0d without a real root, %0d degenerate.",
                 solved_seen, no_root_seen, degenerate_seen);
        if (fail_count == 0 && outstanding == 0) begin
            $display("[w_mass_neutrino_pz_solver_top] OK");
        end else begin
            $display("[w_mass_neutrino_pz_solver_top] ERROR");
        end
        $finish;
    end

endmodule
